/* src/prmb_pkg.sv */
package prmb_pkg;

  // default feature list depth
  localparam int MAX_FEATURES_DEF = 1024;

  // field widths
  localparam int CMD_W   = 2;
  localparam int POS_W   = 32;
  localparam int STAT_W  = 3;
  localparam int MAP_W   = 56;
  localparam int RATE_W  = 48;
  localparam int IN_W    = 4 * POS_W;
  localparam int OUT_W   = MAP_W + RATE_W;

  localparam logic [MAP_W-1:0] MAP_MAX = {MAP_W{1'b1}};

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_TABLE = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FND  = 3'd4;

  // configuration register indexes
  localparam logic REG_CHR_LEN    = 1'b0;
  localparam logic REG_RATE_SCALE = 1'b1;

  // arithmetic unit operations
  localparam logic OP_SCALE = 1'b0;
  localparam logic OP_MADD  = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } mac_req_t;

endpackage

/* src/prmb_mac.sv */
// shared multiply unit: rate scaling, or saturating base + rate * distance
module prmb_mac (
  input  logic                           clk,
  input  logic                           rst,
  input  prmb_pkg::mac_req_t             req,
  input  logic [prmb_pkg::MAP_W-1:0]     base,
  input  logic [prmb_pkg::RATE_W-1:0]    rate,
  input  logic [prmb_pkg::POS_W-1:0]     factor,
  output logic                           done,
  output logic [prmb_pkg::MAP_W-1:0]     result
);

  logic [2:0]                        cnt;
  logic                              op_q;
  logic [prmb_pkg::MAP_W-1:0]        base_q;
  logic [prmb_pkg::RATE_W-1:0]       rate_q;
  logic [prmb_pkg::POS_W-1:0]        factor_q;
  logic [63:0]                       p_lo;
  logic [47:0]                       p_hi;
  logic [prmb_pkg::MAP_W-1:0]        prod_sat;
  logic [31:0]                       mul_a;
  logic [63:0]                       prod;
  logic [80:0]                       prod_full;
  logic [prmb_pkg::MAP_W:0]          sum;

  // one 32x32 multiplier, low then high half of the rate
  assign mul_a = (cnt == 3'd1) ? rate_q[31:0] : {16'b0, rate_q[47:32]};
  assign prod  = {32'b0, mul_a} * {32'b0, factor_q};
  assign prod_full = {17'b0, p_lo} + {1'b0, p_hi, 32'b0};
  assign sum = {1'b0, base_q} + {1'b0, prod_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cnt)
        3'd0: begin
          if (req.start) begin
            op_q     <= req.op;
            base_q   <= base;
            rate_q   <= rate;
            factor_q <= factor;
            cnt      <= 3'd1;
          end
        end
        3'd1: begin
          p_lo <= prod;
          if (op_q == prmb_pkg::OP_SCALE) begin
            result <= {8'b0, prod[63:16]};
            done   <= 1'b1;
            cnt    <= 3'd0;
          end else begin
            cnt <= 3'd2;
          end
        end
        3'd2: begin
          p_hi <= prod[47:0];
          cnt  <= 3'd3;
        end
        3'd3: begin
          // saturate the full product
          prod_sat <= (prod_full > {25'b0, prmb_pkg::MAP_MAX}) ? prmb_pkg::MAP_MAX
                                                               : prod_full[55:0];
          cnt <= 3'd4;
        end
        3'd4: begin
          result <= sum[prmb_pkg::MAP_W] ? prmb_pkg::MAP_MAX : sum[prmb_pkg::MAP_W-1:0];
          done   <= 1'b1;
          cnt    <= 3'd0;
        end
        default: cnt <= 3'd0;
      endcase
    end
  end

endmodule

/* src/piecewise_rate_map_builder_lookup.sv */
// channel | dir | tdata (low bit up)                          | tuser
// s_*     | in  | feature_start, feature_end, score, query_pos | cmd
// m_*     | out | map_pos, rate_out                            | status
//
// one item at a time; s_tready is high only while the sequencer is idle
// load: written straight to the feature memory, or, when it overlaps the last kept feature,
//   after two feature memory reads; finish: per kept feature a feature read, a rate scaling
//   and a block push, plus one more push per gap or tail block (one pass of the multiply-add
//   each) and a final total map position multiply-add; the first block push skips the multiply
// query: a block memory read per cursor step, then the map position multiply;
//   rst is synchronous, memories need no clearing
// a result waiting on m_tready holds the sequencer in its emit step only
module piecewise_rate_map_builder_lookup #(
  parameter int MAX_FEATURES = prmb_pkg::MAX_FEATURES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // feature_start, feature_end, feature_score, query_pos
  input  logic [prmb_pkg::IN_W-1:0]     s_tdata,
  // cmd
  input  logic [prmb_pkg::CMD_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // map_pos, rate_out
  output logic [prmb_pkg::OUT_W-1:0]    m_tdata,
  // status
  output logic [prmb_pkg::STAT_W-1:0]   m_tuser
);

  localparam int FAW = $clog2(MAX_FEATURES);
  localparam int FCW = $clog2(MAX_FEATURES + 1);
  localparam int MAX_BLOCKS = 2 * MAX_FEATURES + 1;
  localparam int BAW = $clog2(MAX_BLOCKS);
  localparam int BCW = $clog2(MAX_BLOCKS + 1);
  localparam int PW = prmb_pkg::POS_W;
  localparam int RW = prmb_pkg::RATE_W;
  localparam int MW = prmb_pkg::MAP_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_EMIT  = 5'd1;
  localparam logic [4:0] L_W1    = 5'd2;
  localparam logic [4:0] L_D1    = 5'd3;
  localparam logic [4:0] L_W2    = 5'd4;
  localparam logic [4:0] L_D2    = 5'd5;
  localparam logic [4:0] F_RD    = 5'd6;
  localparam logic [4:0] F_DAT   = 5'd7;
  localparam logic [4:0] F_SCL   = 5'd8;
  localparam logic [4:0] P_GO    = 5'd9;
  localparam logic [4:0] P_MW    = 5'd10;
  localparam logic [4:0] P_WR    = 5'd11;
  localparam logic [4:0] F_TAIL  = 5'd12;
  localparam logic [4:0] F_TOT   = 5'd13;
  localparam logic [4:0] F_TOTW  = 5'd14;
  localparam logic [4:0] Q_RD    = 5'd15;
  localparam logic [4:0] Q_CHK   = 5'd16;
  localparam logic [4:0] Q_MW    = 5'd17;

  localparam logic [1:0] PK_GAP  = 2'd0;
  localparam logic [1:0] PK_FEAT = 2'd1;
  localparam logic [1:0] PK_TAIL = 2'd2;

  // configuration
  logic [PW-1:0] chr_len;
  logic [PW-1:0] rate_scale;

  // control state
  logic [4:0]     state;
  logic [FCW-1:0] feat_count;
  logic [PW-1:0]  last_kept_end;
  logic [BCW-1:0] blk_count;
  logic [BAW-1:0] cursor;
  logic           table_ready;
  logic           dir_up;
  logic [1:0]     pk;
  logic [FCW-1:0] fi;
  logic [FAW-1:0] fa;

  // working registers
  logic [PW-1:0] in_s, in_e, in_sc, qpos;
  logic [PW-1:0] o_s, o_e;
  logic [PW-1:0] cf_s, cf_e;
  logic [RW-1:0] fr;
  logic [PW-1:0] p_s, p_e;
  logic [RW-1:0] p_r;
  logic [MW-1:0] p_m;
  logic [PW-1:0] lb_start, lb_end;
  logic [RW-1:0] lb_rate, q_rate;
  logic [MW-1:0] lb_mappos;
  logic [prmb_pkg::STAT_W-1:0] res_st;
  logic [MW-1:0] res_mp;
  logic [RW-1:0] res_rate;

  // memories and their registered ports
  logic [PW-1:0] feat_start_mem [MAX_FEATURES];
  logic [PW-1:0] feat_end_mem [MAX_FEATURES];
  logic [PW-1:0] feat_rate_mem [MAX_FEATURES];
  logic [PW-1:0] blk_start_mem [MAX_BLOCKS];
  logic [PW-1:0] blk_end_mem [MAX_BLOCKS];
  logic [RW-1:0] blk_rate_mem [MAX_BLOCKS];
  logic [MW-1:0] blk_mappos_mem [MAX_BLOCKS];
  logic           fw_en;
  logic [FAW-1:0] fw_addr;
  logic [PW-1:0]  fw_s, fw_e, fw_sc;
  logic           bw_en;
  logic [BAW-1:0] bw_addr;
  logic [PW-1:0]  bw_s, bw_e;
  logic [RW-1:0]  bw_r;
  logic [MW-1:0]  bw_m;
  logic [PW-1:0]  frd_s, frd_e, frd_sc;
  logic [PW-1:0]  brd_s, brd_e;
  logic [RW-1:0]  brd_r;
  logic [MW-1:0]  brd_m;

  // shared unit
  prmb_pkg::mac_req_t mac_req;
  logic [MW-1:0] mac_base, mac_res;
  logic [RW-1:0] mac_rate;
  logic [PW-1:0] mac_dist;
  logic          mac_done;

  // input fields
  logic [PW-1:0] s_fs, s_fe, s_fsc, s_qp;
  assign s_fs  = s_tdata[PW-1:0];
  assign s_fe  = s_tdata[2*PW-1:PW];
  assign s_fsc = s_tdata[3*PW-1:2*PW];
  assign s_qp  = s_tdata[4*PW-1:3*PW];

  assign s_tready = (state == S_IDLE);

  // query walk decisions
  logic q_down, q_up, q_miss;
  logic [BCW-1:0] blk_last;
  assign blk_last = blk_count - BCW'(1);
  assign q_down = !dir_up && (cursor != '0) && (brd_s > qpos);
  assign q_up   = (BCW'(cursor) < blk_last) && (brd_e < qpos);
  assign q_miss = (brd_s > qpos) || (brd_e < qpos);

  // finish helpers
  logic [PW:0]   lb_end_p1;
  logic [RW:0]   gap_sum;
  logic [MW:0]   rs_sum;
  logic [FCW-1:0] fi_p1;
  assign lb_end_p1 = {1'b0, lb_end} + (PW+1)'(1);
  assign gap_sum   = {1'b0, lb_rate} + {1'b0, mac_res[RW-1:0]};
  assign rs_sum    = {1'b0, mac_res} + {9'b0, lb_rate};
  assign fi_p1     = fi + FCW'(1);

  // load helpers
  logic [FCW-1:0] fc_m1, fc_m2;
  assign fc_m1 = feat_count - FCW'(1);
  assign fc_m2 = feat_count - FCW'(2);

  // operand select for the shared unit
  always_comb begin
    mac_req.start = 1'b0;
    mac_req.op    = prmb_pkg::OP_MADD;
    mac_base = lb_mappos;
    mac_rate = lb_rate;
    mac_dist = lb_end - lb_start;
    case (state)
      F_DAT: begin
        mac_req.start = 1'b1;
        mac_req.op    = prmb_pkg::OP_SCALE;
        mac_rate = {16'b0, frd_sc};
        mac_dist = rate_scale;
      end
      P_GO:  mac_req.start = (blk_count != '0);
      F_TOT: mac_req.start = 1'b1;
      Q_CHK: begin
        mac_req.start = !q_down && !q_up && !q_miss;
        mac_base = brd_m;
        mac_rate = brd_r;
        mac_dist = qpos - brd_s;
      end
      default: mac_req.start = 1'b0;
    endcase
  end

  prmb_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .req    (mac_req),
    .base   (mac_base),
    .rate   (mac_rate),
    .factor (mac_dist),
    .done   (mac_done),
    .result (mac_res)
  );

  // feature memory
  always_ff @(posedge clk) begin
    if (fw_en) begin
      feat_start_mem[fw_addr] <= fw_s;
      feat_end_mem[fw_addr]   <= fw_e;
      feat_rate_mem[fw_addr]  <= fw_sc;
    end
    frd_s  <= feat_start_mem[fa];
    frd_e  <= feat_end_mem[fa];
    frd_sc <= feat_rate_mem[fa];
  end

  // block memory
  always_ff @(posedge clk) begin
    if (bw_en) begin
      blk_start_mem[bw_addr]  <= bw_s;
      blk_end_mem[bw_addr]    <= bw_e;
      blk_rate_mem[bw_addr]   <= bw_r;
      blk_mappos_mem[bw_addr] <= bw_m;
    end
    brd_s <= blk_start_mem[cursor];
    brd_e <= blk_end_mem[cursor];
    brd_r <= blk_rate_mem[cursor];
    brd_m <= blk_mappos_mem[cursor];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chr_len    <= PW'(1);
      rate_scale <= PW'(65536);
    end else if (cfg_we) begin
      case (cfg_addr)
        prmb_pkg::REG_CHR_LEN:    chr_len    <= cfg_wdata;
        prmb_pkg::REG_RATE_SCALE: rate_scale <= cfg_wdata;
        default:                  chr_len    <= chr_len;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      feat_count    <= '0;
      last_kept_end <= '0;
      blk_count     <= '0;
      cursor        <= '0;
      table_ready   <= 1'b0;
      m_tvalid      <= 1'b0;
      fw_en         <= 1'b0;
      bw_en         <= 1'b0;
      dir_up        <= 1'b0;
      pk            <= PK_GAP;
      fi            <= '0;
      fa            <= '0;
    end else begin
      fw_en <= 1'b0;
      bw_en <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            res_st   <= prmb_pkg::ST_OK;
            res_mp   <= '0;
            res_rate <= '0;
            state    <= S_EMIT;
            case (s_tuser)
              prmb_pkg::CMD_LOAD: begin
                in_s  <= s_fs;
                in_e  <= s_fe;
                in_sc <= s_fsc;
                if (s_fs == '0 || s_fe < s_fs) begin
                  res_st <= prmb_pkg::ST_BAD;
                end else if (s_fs < last_kept_end && feat_count != '0) begin
                  fa    <= fc_m1[FAW-1:0];
                  state <= L_W1;
                end else if (feat_count == FCW'(MAX_FEATURES)) begin
                  res_st <= prmb_pkg::ST_FULL;
                end else begin
                  fw_en         <= 1'b1;
                  fw_addr       <= feat_count[FAW-1:0];
                  fw_s          <= s_fs;
                  fw_e          <= s_fe;
                  fw_sc         <= s_fsc;
                  last_kept_end <= s_fe;
                  feat_count    <= feat_count + FCW'(1);
                end
              end
              prmb_pkg::CMD_FINISH: begin
                blk_count   <= '0;
                cursor      <= '0;
                table_ready <= 1'b0;
                if (feat_count == '0) begin
                  res_st <= prmb_pkg::ST_NO_TABLE;
                end else begin
                  fi    <= '0;
                  fa    <= '0;
                  state <= F_RD;
                end
              end
              prmb_pkg::CMD_QUERY: begin
                qpos <= s_qp;
                if (!table_ready || blk_count == '0) begin
                  res_st <= prmb_pkg::ST_NO_TABLE;
                end else begin
                  if (BCW'(cursor) >= blk_count) begin
                    cursor <= blk_last[BAW-1:0];
                  end
                  dir_up <= 1'b0;
                  state  <= Q_RD;
                end
              end
              default: res_st <= prmb_pkg::ST_OK;
            endcase
          end
        end

        // overlap with the last kept feature
        L_W1: state <= L_D1;
        L_D1: begin
          o_s   <= frd_s;
          o_e   <= frd_e;
          fa    <= fc_m2[FAW-1:0];
          state <= L_W2;
        end
        L_W2: state <= L_D2;
        L_D2: begin
          state <= S_EMIT;
          if ((in_e - in_s) > (o_e - o_s)) begin
            fw_addr <= fc_m1[FAW-1:0];
            fw_e    <= in_e;
            fw_sc   <= in_sc;
            fw_s    <= in_s;
            fw_en   <= 1'b1;
            last_kept_end <= in_e;
            if (feat_count > FCW'(1) && frd_e >= in_s) begin
              if (frd_e >= in_e) begin
                // shortened to nothing: drop it
                fw_en         <= 1'b0;
                feat_count    <= fc_m1;
                last_kept_end <= frd_e;
              end else begin
                fw_s <= frd_e + PW'(1);
              end
            end
          end
        end

        // finish: walk the kept features
        F_RD: state <= F_DAT;
        F_DAT: begin
          cf_s  <= frd_s;
          cf_e  <= frd_e;
          state <= F_SCL;
        end
        F_SCL: begin
          if (mac_done) begin
            fr    <= mac_res[RW-1:0];
            state <= P_GO;
            if (blk_count == '0) begin
              if (cf_s > PW'(1)) begin
                p_s <= PW'(1);
                p_e <= cf_s - PW'(1);
                p_r <= mac_res[RW-1:0];
                pk  <= PK_GAP;
              end else begin
                p_s <= cf_s;
                p_e <= cf_e;
                p_r <= mac_res[RW-1:0];
                pk  <= PK_FEAT;
              end
            end else if ({1'b0, cf_s} > lb_end_p1) begin
              p_s <= lb_end_p1[PW-1:0];
              p_e <= cf_s - PW'(1);
              p_r <= gap_sum[RW:1];
              pk  <= PK_GAP;
            end else begin
              p_s <= cf_s;
              p_e <= cf_e;
              p_r <= mac_res[RW-1:0];
              pk  <= PK_FEAT;
            end
          end
        end

        // block push: map position continues from the last block
        P_GO: begin
          if (blk_count == '0) begin
            p_m   <= '0;
            state <= P_WR;
          end else begin
            state <= P_MW;
          end
        end
        P_MW: begin
          if (mac_done) begin
            p_m   <= rs_sum[MW] ? prmb_pkg::MAP_MAX : rs_sum[MW-1:0];
            state <= P_WR;
          end
        end
        P_WR: begin
          bw_en     <= 1'b1;
          bw_addr   <= blk_count[BAW-1:0];
          bw_s      <= p_s;
          bw_e      <= p_e;
          bw_r      <= p_r;
          bw_m      <= p_m;
          lb_start  <= p_s;
          lb_end    <= p_e;
          lb_rate   <= p_r;
          lb_mappos <= p_m;
          blk_count <= blk_count + BCW'(1);
          case (pk)
            PK_GAP: begin
              p_s   <= cf_s;
              p_e   <= cf_e;
              p_r   <= fr;
              pk    <= PK_FEAT;
              state <= P_GO;
            end
            PK_FEAT: begin
              if (fi_p1 == feat_count) begin
                state <= F_TAIL;
              end else begin
                fi    <= fi_p1;
                fa    <= fi_p1[FAW-1:0];
                state <= F_RD;
              end
            end
            default: state <= F_TOT;
          endcase
        end
        F_TAIL: begin
          if (lb_end < chr_len) begin
            p_s   <= lb_end_p1[PW-1:0];
            p_e   <= chr_len;
            p_r   <= lb_rate;
            pk    <= PK_TAIL;
            state <= P_GO;
          end else begin
            state <= F_TOT;
          end
        end
        F_TOT: state <= F_TOTW;
        F_TOTW: begin
          if (mac_done) begin
            res_mp        <= mac_res;
            table_ready   <= 1'b1;
            feat_count    <= '0;
            last_kept_end <= '0;
            state         <= S_EMIT;
          end
        end

        // query: cursor walk, one block read per step
        Q_RD: state <= Q_CHK;
        Q_CHK: begin
          if (q_down) begin
            cursor <= cursor - BAW'(1);
            state  <= Q_RD;
          end else if (q_up) begin
            dir_up <= 1'b1;
            cursor <= cursor + BAW'(1);
            state  <= Q_RD;
          end else if (q_miss) begin
            res_st <= prmb_pkg::ST_NOT_FND;
            state  <= S_EMIT;
          end else begin
            q_rate <= brd_r;
            state  <= Q_MW;
          end
        end
        Q_MW: begin
          if (mac_done) begin
            res_mp   <= mac_res;
            res_rate <= q_rate;
            state    <= S_EMIT;
          end
        end

        // hand the result to the output register
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_st;
            m_tdata  <= {res_rate, res_mp};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_cursor_in_table: assert property (@(posedge clk) disable iff (rst)
    table_ready |-> (BCW'(cursor) < blk_count))
    else $error("cursor beyond block table");

  a_table_nonempty: assert property (@(posedge clk) disable iff (rst)
    table_ready |-> (blk_count != '0))
    else $error("table marked ready with no blocks");

  a_feat_bound: assert property (@(posedge clk) disable iff (rst)
    feat_count <= FCW'(MAX_FEATURES))
    else $error("feature count beyond list depth");

  a_mac_expected: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == F_SCL || state == P_MW || state == F_TOTW || state == Q_MW))
    else $error("multiply result with no step waiting");

endmodule

/* dv/prmb_checker.sv */
module prmb_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [31:0]                   cfg_wdata,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [prmb_pkg::IN_W-1:0]     s_tdata,
  input  logic [prmb_pkg::CMD_W-1:0]    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [prmb_pkg::OUT_W-1:0]    m_tdata,
  input  logic [prmb_pkg::STAT_W-1:0]   m_tuser,
  output int                            fail_count,
  output int                            pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFEAT = prmb_pkg::MAX_FEATURES_DEF;
  localparam int NBLK  = 2 * NFEAT + 1;
  localparam logic [63:0] M56 = 64'h00FF_FFFF_FFFF_FFFF;
  localparam logic [63:0] M48 = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct {
    logic [prmb_pkg::STAT_W-1:0] status;
    logic [prmb_pkg::MAP_W-1:0]  map_pos;
    logic [prmb_pkg::RATE_W-1:0] rate;
  } map_result_t;

  map_result_t expected_results[$];

  // mirrored configuration
  logic [63:0] chr_len_q, rate_scale_q;

  // kept feature list
  logic [31:0] f_start[NFEAT];
  logic [31:0] f_end[NFEAT];
  logic [31:0] f_score[NFEAT];
  int unsigned f_cnt;
  logic [31:0] kept_end;

  // block table and lookup cursor
  logic [31:0] b_start[NBLK];
  logic [31:0] b_end[NBLK];
  logic [63:0] b_rate[NBLK];
  logic [63:0] b_map[NBLK];
  int unsigned b_cnt, cur;
  bit table_ok;

  map_result_t pred, got;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > M56) ? M56 : s;
  endfunction

  function automatic logic [63:0] sat_prod(logic [63:0] r, logic [63:0] d);
    if (d != 0 && r > M56 / d) return M56;
    return r * d;
  endfunction

  function automatic logic [63:0] scaled(logic [31:0] score);
    return ((64'(score) * rate_scale_q) >> 16) & M48;
  endfunction

  function automatic logic [63:0] block_end_map(int unsigned n);
    return sat_sum(b_map[n], sat_prod(b_rate[n], 64'(b_end[n]) - 64'(b_start[n])));
  endfunction

  // append a block, map position continues from the previous one
  function automatic void append_block(logic [63:0] s, logic [63:0] e, logic [63:0] r);
    logic [63:0] m;
    m = 0;
    if (b_cnt >= NBLK) return;
    if (b_cnt > 0) m = sat_sum(block_end_map(b_cnt - 1), b_rate[b_cnt - 1]);
    b_start[b_cnt] = s[31:0];
    b_end[b_cnt]   = e[31:0];
    b_rate[b_cnt]  = r;
    b_map[b_cnt]   = m;
    b_cnt++;
  endfunction

  // overlap resolution on a load
  function automatic logic [prmb_pkg::STAT_W-1:0] load_feature(logic [31:0] s,
                                                                logic [31:0] e,
                                                                logic [31:0] sc);
    int unsigned n;
    logic [63:0] old_len, new_len, ns;
    n = f_cnt;
    if (s == 0 || e < s) return prmb_pkg::ST_BAD;
    if (s < kept_end && n > 0) begin
      old_len = 64'(f_end[n-1]) - 64'(f_start[n-1]) + 1;
      new_len = 64'(e) - 64'(s) + 1;
      if (new_len > old_len) begin
        f_start[n-1] = s;
        f_end[n-1]   = e;
        f_score[n-1] = sc;
        kept_end     = e;
        if (n > 1 && f_end[n-2] >= s) begin
          ns = 64'(f_end[n-2]) + 1;
          if (ns > 64'(e)) begin
            f_cnt    = n - 1;
            kept_end = f_end[n-2];
          end else begin
            f_start[n-1] = ns[31:0];
          end
        end
      end
      return prmb_pkg::ST_OK;
    end
    if (n >= NFEAT) return prmb_pkg::ST_FULL;
    f_start[n] = s;
    f_end[n]   = e;
    f_score[n] = sc;
    kept_end   = e;
    f_cnt      = n + 1;
    return prmb_pkg::ST_OK;
  endfunction

  // gap-free block table over the kept features
  function automatic logic [prmb_pkg::STAT_W-1:0] build_table(output logic [63:0] total);
    logic [63:0] fr;
    int unsigned p;
    total    = 0;
    b_cnt    = 0;
    cur      = 0;
    table_ok = 0;
    if (f_cnt == 0) return prmb_pkg::ST_NO_TABLE;
    if (f_start[0] > 1) append_block(1, 64'(f_start[0]) - 1, scaled(f_score[0]));
    for (int unsigned i = 0; i < f_cnt; i++) begin
      fr = scaled(f_score[i]);
      if (b_cnt > 0) begin
        p = b_cnt - 1;
        if (64'(f_start[i]) > 64'(b_end[p]) + 1)
          append_block(64'(b_end[p]) + 1, 64'(f_start[i]) - 1, (b_rate[p] + fr) >> 1);
      end
      append_block(f_start[i], f_end[i], fr);
    end
    if (64'(b_end[b_cnt-1]) < chr_len_q)
      append_block(64'(b_end[b_cnt-1]) + 1, chr_len_q, b_rate[b_cnt-1]);
    total    = block_end_map(b_cnt - 1);
    table_ok = 1;
    f_cnt    = 0;
    kept_end = 0;
    return prmb_pkg::ST_OK;
  endfunction

  // cursor walk to the block holding the position
  function automatic logic [prmb_pkg::STAT_W-1:0] lookup(logic [31:0] pos,
                                                          output logic [63:0] mp,
                                                          output logic [63:0] r);
    int unsigned c;
    mp = 0;
    r  = 0;
    if (!table_ok || b_cnt == 0) return prmb_pkg::ST_NO_TABLE;
    c = (cur >= b_cnt) ? b_cnt - 1 : cur;
    while (c > 0 && b_start[c] > pos) c--;
    while (c < b_cnt - 1 && b_end[c] < pos) c++;
    cur = c;
    if (b_start[c] > pos || b_end[c] < pos) return prmb_pkg::ST_NOT_FND;
    mp = sat_sum(b_map[c], sat_prod(b_rate[c], 64'(pos) - 64'(b_start[c])));
    r  = b_rate[c];
    return prmb_pkg::ST_OK;
  endfunction

  function automatic map_result_t predict(logic [prmb_pkg::CMD_W-1:0] cmd,
                                          logic [prmb_pkg::IN_W-1:0] d);
    map_result_t res;
    logic [63:0] mp, r;
    mp = 0;
    r  = 0;
    res.status = prmb_pkg::ST_OK;
    case (cmd)
      prmb_pkg::CMD_LOAD:   res.status = load_feature(d[31:0], d[63:32], d[95:64]);
      prmb_pkg::CMD_FINISH: res.status = build_table(mp);
      prmb_pkg::CMD_QUERY:  res.status = lookup(d[127:96], mp, r);
      default: ;
    endcase
    res.map_pos = mp[prmb_pkg::MAP_W-1:0];
    res.rate    = r[prmb_pkg::RATE_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      chr_len_q    = 1;
      rate_scale_q = 65536;
      f_cnt        = 0;
      kept_end     = 0;
      b_cnt        = 0;
      cur          = 0;
      table_ok     = 0;
      expected_results.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_addr == prmb_pkg::REG_CHR_LEN) chr_len_q = 64'(cfg_wdata);
        else rate_scale_q = 64'(cfg_wdata);
      end
      // accepted request
      if (s_tvalid && s_tready) expected_results.push_back(predict(s_tuser, s_tdata));
      // accepted result
      if (m_tvalid && m_tready) begin
        got.status  = m_tuser;
        got.map_pos = m_tdata[prmb_pkg::MAP_W-1:0];
        got.rate    = m_tdata[prmb_pkg::OUT_W-1:prmb_pkg::MAP_W];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d map %h rate %h",
                   $realtime, got.status, got.map_pos, got.rate);
          fail_count++;
        end else begin
          pred = expected_results.pop_front();
          if (got.status != pred.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, pred.status,
                     got.status);
            fail_count++;
          end
          if (got.map_pos != pred.map_pos) begin
            $display("%0t: map_pos expected %h actual %h", $realtime, pred.map_pos,
                     got.map_pos);
            fail_count++;
          end
          if (got.rate != pred.rate) begin
            $display("%0t: rate_out expected %h actual %h", $realtime, pred.rate, got.rate);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* dv/tb_top.sv */
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [prmb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 250;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_addr = 0;
  logic [31:0] cfg_wdata = 0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [prmb_pkg::IN_W-1:0] s_tdata = '0;
  logic [prmb_pkg::CMD_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [prmb_pkg::OUT_W-1:0] m_tdata;
  logic [prmb_pkg::STAT_W-1:0] m_tuser;

  int fail_count, pending;
  int random_sent = 0;
  int stall_cycles = 0;
  bit calm = 0;
  bit hold_req = 0;
  logic [31:0] cur_chr_len = 1;

  always #2 clk = ~clk;

  piecewise_rate_map_builder_lookup dut (.*);

  prmb_checker u_checker (.*);

  // request channel driver; tvalid stays high when the next request follows directly
  task automatic send(logic [prmb_pkg::CMD_W-1:0] cmd, logic [31:0] fs, logic [31:0] fe,
                      logic [31:0] sc, logic [31:0] pos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= cmd;
    s_tdata  <= {pos, sc, fe, fs};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic load(logic [31:0] fs, logic [31:0] fe, logic [31:0] sc);
    send(prmb_pkg::CMD_LOAD, fs, fe, sc, $urandom());
  endtask

  task automatic query(logic [31:0] pos);
    send(prmb_pkg::CMD_QUERY, $urandom(), $urandom(), $urandom(), pos);
  endtask

  task automatic finish_build();
    send(prmb_pkg::CMD_FINISH, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  // registers change only with nothing in flight
  task automatic write_regs(logic [31:0] len, logic [31:0] scale);
    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    cfg_we    <= 1;
    cfg_addr  <= prmb_pkg::REG_CHR_LEN;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_addr  <= prmb_pkg::REG_RATE_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_we <= 0;
    cur_chr_len = len;
  endtask

  function automatic logic [31:0] pick_score();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  // one feature set: sorted loads with overlaps, touches and gaps, some random or invalid loads, a finish, queries
  task automatic run_set(int nfeat, bit high_base);
    logic [63:0] s, e, len, prev_s, lo, hi, span, pos;
    int nq;
    prev_s = high_base ? 64'h0_FFFF_FFFF - $urandom_range(0, 3000) : $urandom_range(1, 60);
    lo = prev_s;
    hi = prev_s;
    for (int i = 0; i < nfeat; i++) begin
      case ($urandom_range(0, 19))
        0: load($urandom(), $urandom(), $urandom());
        1: if ($urandom_range(0, 1)) load(0, $urandom(), pick_score());
           else load(prev_s[31:0] + 5, prev_s[31:0] + 4, pick_score());
        default: begin
          s = prev_s + $urandom_range(0, 30);
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 1 << 24)
                                              : $urandom_range(1, 25);
          if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
          e = s + len - 1;
          if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
          prev_s = s;
          if (e > hi) hi = e;
          load(s[31:0], e[31:0], pick_score());
        end
      endcase
      random_sent++;
    end
    finish_build();
    nq = $urandom_range(3, 12);
    if (64'(cur_chr_len) > hi) hi = 64'(cur_chr_len);
    span = hi - lo + 8;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    for (int i = 0; i < nq; i++) begin
      case ($urandom_range(0, 6))
        0: pos = $urandom();
        1: pos = 0;
        2: pos = cur_chr_len;
        default: pos = (lo > 4 ? lo - 4 : 0) + $urandom_range(0, span[31:0]);
      endcase
      query(pos[31:0]);
    end
    random_sent += nq + 1;
  endtask

  // result channel: random stalls, one long hold-off on request
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 11);
      if (hold_req) begin
        hold_req = 0;
        gap = 400;
      end
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("piecewise_rate_map_builder_lookup verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] len, scale;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // before any table, with reset register values
    query(5);
    finish_build();
    send(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load(0, 10, 7);
    load(20, 19, 7);
    // one full-width feature, saturating map
    load(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    finish_build();
    query(0);
    query(32'hFFFF_FFFF);
    query(32'h8000_0000);

    // overlap cases: longer replaces, touching kept, shortened away, shorter dropped
    write_regs(100, 65536);
    load(10, 30, 32'h0001_0000);
    load(30, 31, 32'h0002_0000);
    load(12, 29, 32'h0003_0000);
    load(40, 50, 32'h0000_8000);
    load(45, 70, 32'h0004_0000);
    load(60, 62, 32'h0001_0000);
    finish_build();
    query(1);
    query(35);
    query(100);
    query(101);
    query(9);

    // feature list overflow
    write_regs(12000, 32'h0000_1000);
    calm = 1;
    for (int i = 0; i < prmb_pkg::MAX_FEATURES_DEF + 4; i++)
      load(10 * i + 1, 10 * i + 5, $urandom());
    finish_build();
    calm = 0;
    for (int i = 0; i < 16; i++) query($urandom_range(0, 12010));

    // random feature sets over changing register settings
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: len = 1;
          1: len = 32'hFFFF_FFFF;
          2: len = $urandom_range(1, 400);
          default: len = $urandom();
        endcase
        case ($urandom_range(0, 3))
          0: scale = 0;
          1: scale = 32'hFFFF_FFFF;
          2: scale = 65536;
          default: scale = $urandom();
        endcase
        write_regs(len, scale);
      end
      calm = ($urandom_range(0, 4) == 0);
      if (random_sent > 100 && random_sent < 130) hold_req = 1;
      run_set($urandom_range(1, 14), $urandom_range(0, 3) == 0);
    end

    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("piecewise_rate_map_builder_lookup verification clean");
    end else begin
      $display("piecewise_rate_map_builder_lookup verification failed");
    end
    $finish;
  end

endmodule
